FILE: rtl/text_console_glyph_renderer_top_defines.svh
// ----------------------------------------------------------------------------
// Text console glyph renderer: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, with the
// check disabled while the synchronous reset is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_TOP_DEFINES_SVH

// same-cycle implication
`define TCGR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCGR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Constants, register reset values, codes and the sequencer control store.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int FONT_BYTES_DEF = 4096;
    localparam int GLYPH_ROWS_DEF = 16;
    localparam int GLYPH_COLS     = 8;

    localparam int CURSOR_W    = 12;
    localparam int INDEX_W     = 24;
    localparam int MASK_W      = 8;
    localparam int COLOR_W     = 32;
    localparam int PITCH_W     = 13;
    localparam int BPG_W       = 5;
    localparam int CODE_W      = 8;
    localparam int FADDR_W     = 12;
    localparam int ACTION_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 64;
    // glyph byte address: code * bytes_per_glyph + row
    localparam int RD_ADDR_W   = 13;

    localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;

    localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST  = 32'hffff_ffff;
    localparam logic [PITCH_W-1:0] LINE_PITCH_RST   = 13'd1024;
    localparam logic [PITCH_W-1:0] SCREEN_WIDTH_RST = 13'd1024;
    localparam logic [BPG_W-1:0]   BPG_RST          = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_PRINT   = 2'd1,
        ACT_NEWLINE = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COLOR  = 2'd0,
        CFG_LINE_PITCH   = 2'd1,
        CFG_SCREEN_WIDTH = 2'd2,
        CFG_BPG          = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        STEP_IDLE  = 3'd0,
        STEP_NL    = 3'd1,
        STEP_MUL   = 3'd2,
        STEP_PRIME = 3'd3,
        STEP_EMIT  = 3'd4,
        STEP_ADV   = 3'd5
    } step_t;

    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_DISPATCH = 2'd1,
        JMP_ROWLOOP  = 2'd2
    } jmp_t;

    typedef struct packed {
        logic  accept;
        logic  do_nl;
        logic  do_mul;
        logic  do_prime;
        logic  do_emit;
        logic  do_adv;
        jmp_t  jump;
        step_t next;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t uc;
        uc = '{accept: 1'b0, do_nl: 1'b0, do_mul: 1'b0, do_prime: 1'b0,
               do_emit: 1'b0, do_adv: 1'b0, jump: JMP_NEXT, next: STEP_IDLE};
        unique case (step)
            STEP_IDLE: begin
                uc.accept = 1'b1;
                uc.jump   = JMP_DISPATCH;
            end
            STEP_NL: begin
                uc.do_nl = 1'b1;
            end
            STEP_MUL: begin
                uc.do_mul = 1'b1;
                uc.next   = STEP_PRIME;
            end
            STEP_PRIME: begin
                uc.do_prime = 1'b1;
                uc.next     = STEP_EMIT;
            end
            STEP_EMIT: begin
                uc.do_emit = 1'b1;
                uc.jump    = JMP_ROWLOOP;
                uc.next    = STEP_ADV;
            end
            STEP_ADV: begin
                uc.do_adv = 1'b1;
            end
            default: begin
                uc.next = STEP_IDLE;
            end
        endcase
        return uc;
    endfunction

endpackage

FILE: rtl/text_console_glyph_renderer_top.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Bitmap-font character generator driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Input beats (s_) carry one item: s_tuser selects load, print or newline.
// A load beat writes one byte of the font store. A newline beat moves the
// cursor to the next text line. A print beat runs one multiply step, one
// font memory prime step, one row write beat per cycle on m_ while the
// receiver accepts, and a cursor update step. The single read port of
// the font memory and the output register set the one-row-per-cycle
// pace. The first row write leaves after the multiply and prime steps;
// m_tlast marks the final row. s_tready is high only while the sequencer
// waits for an item. If the receiver holds m_tready low, the row loop
// stops in place and resumes without loss. Reset clears the cursor, the
// registers to their defaults and the output valid; font store contents
// are undefined until loaded. Configuration writes on cfg_ take effect at
// once and belong in idle periods.
// ----------------------------------------------------------------------------
`include "text_console_glyph_renderer_top_defines.svh"

module text_console_glyph_renderer_top #(
    parameter int FONT_BYTES = tcgr_pkg::FONT_BYTES_DEF,
    parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] char_code, [19:8] font_address, [27:20] glyph_byte
    input  logic [tcgr_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [tcgr_pkg::ACTION_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] pixel_index, [31:24] pixel_mask, [63:32] write_color
    output logic [tcgr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int MEM_AW = $clog2(FONT_BYTES);
    localparam int ROW_W  = $clog2(GLYPH_ROWS);

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

    // input fields
    logic [tcgr_pkg::CODE_W-1:0]  s_char_code;
    logic [tcgr_pkg::FADDR_W-1:0] s_font_address;
    logic [tcgr_pkg::MASK_W-1:0]  s_glyph_byte;
    tcgr_pkg::action_t            s_action;

    assign s_char_code    = s_tdata[7:0];
    assign s_font_address = s_tdata[19:8];
    assign s_glyph_byte   = s_tdata[27:20];
    assign s_action       = tcgr_pkg::action_t'(s_tuser);

    // control
    tcgr_pkg::step_t  step_reg, step_next;
    tcgr_pkg::ucode_t uc;
    logic [ROW_W-1:0] row_reg;
    logic             s_acc;
    logic             out_free;
    logic             emit_fire;
    logic             row_last;

    // configuration
    logic [tcgr_pkg::COLOR_W-1:0] pixel_color_reg;
    logic [tcgr_pkg::PITCH_W-1:0] line_pitch_reg;
    logic [tcgr_pkg::PITCH_W-1:0] screen_width_reg;
    logic [tcgr_pkg::BPG_W-1:0]   bpg_reg;

    // cursor
    logic [tcgr_pkg::CURSOR_W-1:0] cursor_x_reg;
    logic [tcgr_pkg::CURSOR_W-1:0] cursor_y_reg;
    logic [tcgr_pkg::CURSOR_W:0]   x_adv;
    logic [tcgr_pkg::CURSOR_W:0]   y_adv;
    logic [tcgr_pkg::CURSOR_W-1:0] y_nl;
    logic                          wrap;

    // datapath
    logic [tcgr_pkg::CODE_W-1:0]      code_reg;
    logic [tcgr_pkg::RD_ADDR_W-1:0]   base_reg;
    logic [tcgr_pkg::INDEX_W:0]       yprod_reg;
    logic [tcgr_pkg::INDEX_W-1:0]     idx_reg;
    logic [tcgr_pkg::RD_ADDR_W-1:0]   rd_addr_reg;
    logic [tcgr_pkg::RD_ADDR_W-1:0]   rd_addr_mux;
    logic [tcgr_pkg::MASK_W-1:0]      rd_data_reg;
    logic                             rd_ok_reg;
    logic                             rd_issue;
    logic                             rd_in_range;
    logic                             load_we;
    logic [tcgr_pkg::MASK_W-1:0]      font_mem [FONT_BYTES];

    // output register
    logic                            m_tvalid_reg;
    logic                            m_tlast_reg;
    logic [tcgr_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    assign uc        = tcgr_pkg::ucode_rom(step_reg);
    assign s_tready  = uc.accept;
    assign s_acc     = s_tvalid && uc.accept;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = uc.do_emit && out_free;
    assign row_last  = (row_reg == ROW_LAST);

    always_comb begin
        step_next = step_reg;
        case (uc.jump)
            tcgr_pkg::JMP_NEXT: begin
                step_next = uc.next;
            end
            tcgr_pkg::JMP_DISPATCH: begin
                if (s_acc) begin
                    unique case (s_action)
                        tcgr_pkg::ACT_PRINT:   step_next = tcgr_pkg::STEP_MUL;
                        tcgr_pkg::ACT_NEWLINE: step_next = tcgr_pkg::STEP_NL;
                        default:               step_next = tcgr_pkg::STEP_IDLE;
                    endcase
                end
            end
            tcgr_pkg::JMP_ROWLOOP: begin
                if (emit_fire && row_last) begin
                    step_next = uc.next;
                end
            end
            default: begin
                step_next = tcgr_pkg::STEP_IDLE;
            end
        endcase
    end

    // cursor arithmetic
    assign x_adv = {1'b0, cursor_x_reg} + (tcgr_pkg::CURSOR_W + 1)'(tcgr_pkg::GLYPH_COLS);
    assign y_adv = {1'b0, cursor_y_reg} + (tcgr_pkg::CURSOR_W + 1)'(GLYPH_ROWS);
    assign y_nl  = y_adv[tcgr_pkg::CURSOR_W] ? tcgr_pkg::CURSOR_MAX
                                             : y_adv[tcgr_pkg::CURSOR_W-1:0];
    assign wrap  = (x_adv > screen_width_reg) || x_adv[tcgr_pkg::CURSOR_W];

    // font memory addressing
    assign rd_addr_mux = uc.do_prime ? base_reg : rd_addr_reg;
    assign rd_in_range = int'(rd_addr_mux) < FONT_BYTES;
    assign rd_issue    = uc.do_prime || emit_fire;
    assign load_we     = s_acc && (s_action == tcgr_pkg::ACT_LOAD)
                         && (int'(s_font_address) < FONT_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg         <= tcgr_pkg::STEP_IDLE;
            row_reg          <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            pixel_color_reg  <= tcgr_pkg::PIXEL_COLOR_RST;
            line_pitch_reg   <= tcgr_pkg::LINE_PITCH_RST;
            screen_width_reg <= tcgr_pkg::SCREEN_WIDTH_RST;
            bpg_reg          <= tcgr_pkg::BPG_RST;
            m_tvalid_reg     <= 1'b0;
        end else begin
            step_reg <= step_next;

            if (cfg_we) begin
                unique case (tcgr_pkg::cfg_idx_t'(cfg_index))
                    tcgr_pkg::CFG_PIXEL_COLOR:  pixel_color_reg  <= cfg_wdata;
                    tcgr_pkg::CFG_LINE_PITCH:   line_pitch_reg   <= cfg_wdata[12:0];
                    tcgr_pkg::CFG_SCREEN_WIDTH: screen_width_reg <= cfg_wdata[12:0];
                    tcgr_pkg::CFG_BPG:          bpg_reg          <= cfg_wdata[4:0];
                    default: ;
                endcase
            end

            if (uc.do_prime) begin
                row_reg <= '0;
            end else if (emit_fire) begin
                row_reg <= row_reg + ROW_W'(1);
            end

            if (uc.do_nl || (uc.do_adv && wrap)) begin
                cursor_x_reg <= '0;
                cursor_y_reg <= y_nl;
            end else if (uc.do_adv) begin
                cursor_x_reg <= x_adv[tcgr_pkg::CURSOR_W-1:0];
            end

            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            code_reg <= s_char_code;
        end
        if (uc.do_mul) begin
            base_reg  <= {5'b0, code_reg} * {8'b0, bpg_reg};
            yprod_reg <= {13'b0, cursor_y_reg} * {12'b0, line_pitch_reg};
        end
        if (uc.do_prime) begin
            idx_reg <= {12'b0, cursor_x_reg} + yprod_reg[tcgr_pkg::INDEX_W-1:0];
        end else if (emit_fire) begin
            idx_reg <= idx_reg + {11'b0, line_pitch_reg};
        end
        if (rd_issue) begin
            rd_addr_reg <= rd_addr_mux + tcgr_pkg::RD_ADDR_W'(1);
            rd_ok_reg   <= rd_in_range;
        end
        if (emit_fire) begin
            m_tdata_reg <= {pixel_color_reg, (rd_ok_reg ? rd_data_reg : 8'h00), idx_reg};
            m_tlast_reg <= row_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            font_mem[MEM_AW'(s_font_address)] <= s_glyph_byte;
        end
        if (rd_issue && rd_in_range) begin
            rd_data_reg <= font_mem[MEM_AW'(rd_addr_mux)];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `TCGR_ASSERT_NOW(a_cursor_x_aligned, aclk, aresetn, 1'b1,
        cursor_x_reg[2:0] == 3'b000, "cursor x off glyph grid")
    `TCGR_ASSERT_NEXT(a_emit_stall_holds, aclk, aresetn,
        uc.do_emit && !out_free,
        $stable(row_reg) && $stable(idx_reg) && $stable(rd_addr_reg),
        "row loop advanced while output stalled")
    `TCGR_ASSERT_NEXT(a_print_starts_mul, aclk, aresetn,
        s_acc && (s_action == tcgr_pkg::ACT_PRINT),
        step_reg == tcgr_pkg::STEP_MUL, "print beat did not start sequence")

endmodule
